// ===== rtl/core/htw_pkg.sv =====
// Shared constants for the hierarchical timing wheel.
// Field widths, result status codes and input action codes.
// No dependencies.
package htw_pkg;

  localparam int unsigned DELAY_W      = 32;
  localparam int unsigned TID_W        = 16;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned IN_TDATA_W   = 48;
  localparam int unsigned OUT_TDATA_W  = 16;
  localparam int unsigned OUTER_LEVELS = 4;
  localparam int unsigned LAST_LEVEL   = OUTER_LEVELS - 1;

  localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FIRED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

endpackage

// ===== rtl/core/hierarchical_timing_wheel_unit.sv =====
// Five-level timing wheel: list heads, tails and node pool in synchronous memories.
// Depends on htw_pkg.
//
// channel   dir  tdata                              tuser        tlast
// s_axis    in   delay[31:0], timer_id[47:32]       action       -
// m_axis    out  fired_id[15:0]                     status[1:0]  last of the input
//
// Add: accept, head/tail read, link write; a fired or rejected add ends at the accept.
// Tick: a head read, then a next read and an emit per expired timer; a cascade re-links
// each moved timer by a next read, head/tail read and link write in the one-port node memory walk.
// After reset the head memories are swept empty; no word is taken meanwhile.
// An unread result stalls the walk.
module hierarchical_timing_wheel_unit #(
  parameter int unsigned NEAR_BITS  = 8,
  parameter int unsigned LEVEL_BITS = 6,
  parameter int unsigned MAX_TIMERS = 64,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [htw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // delay, timer_id
  input  logic                                s_axis_tuser,  // action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [htw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // fired_id
  output logic [htw_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
  output logic                                m_axis_tlast
);

  localparam int unsigned NODE_BITS  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned PTR_BITS   = NODE_BITS + 1;
  localparam int unsigned NEAR_SLOTS = 1 << NEAR_BITS;
  localparam int unsigned LVL_ADDR   = LEVEL_BITS + 2;
  localparam int unsigned LVL_SLOTS  = 1 << LVL_ADDR;
  localparam int unsigned CLR_BITS   = (NEAR_BITS > LVL_ADDR) ? NEAR_BITS : LVL_ADDR;
  localparam logic [31:0] NEAR_MASK  = 32'((64'd1 << NEAR_BITS) - 64'd1);
  localparam logic [PTR_BITS-1:0] EMPTY = {1'b1, {NODE_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FN_RD, S_FN_HD, S_FN_ND, S_FN_EM, S_SHIFT,
    S_MV_RD, S_MV_HD, S_MV_ND, S_PL_RD, S_PL_WR, S_FLUSH
  } state_e;

  state_e state_q;
  logic [CLR_BITS-1:0] clr_q;
  logic [31:0] tick_q;
  logic phase_q, from_add_q;
  logic [NODE_BITS-1:0] cur_q;
  logic [PTR_BITS-1:0] nx_q;
  logic [ID_BITS-1:0] hid_q;
  logic pl_near_q;
  logic [NEAR_BITS-1:0] pl_nidx_q;
  logic [LVL_ADDR-1:0] pl_lidx_q, mv_slot_q;
  logic [MAX_TIMERS-1:0] free_q;
  logic free_any_q;
  logic [NODE_BITS-1:0] free_idx_q;
  logic pend_v_q;
  logic [ID_BITS-1:0] pend_id_q;
  logic out_v_q, out_last_q;
  logic [htw_pkg::OUT_TDATA_W-1:0] out_id_q;
  logic [htw_pkg::STATUS_W-1:0] out_st_q;

  logic [PTR_BITS-1:0]  near_head [NEAR_SLOTS];
  logic [NODE_BITS-1:0] near_tail [NEAR_SLOTS];
  logic [PTR_BITS-1:0]  level_head [LVL_SLOTS];
  logic [NODE_BITS-1:0] level_tail [LVL_SLOTS];
  logic [PTR_BITS-1:0]  node_next [MAX_TIMERS];
  logic [31:0]          node_exp [MAX_TIMERS];
  logic [ID_BITS-1:0]   node_hdl [MAX_TIMERS];

  logic [PTR_BITS-1:0]  nh_rd_q, lh_rd_q, nn_rd_q;
  logic [NODE_BITS-1:0] nt_rd_q, lt_rd_q;
  logic [31:0]          ne_rd_q;
  logic [ID_BITS-1:0]   nhd_rd_q;

  // memory ports
  logic [NEAR_BITS-1:0] nh_ra, nh_wa;
  logic [LVL_ADDR-1:0]  lh_ra, lh_wa;
  logic [NODE_BITS-1:0] nd_ra, nx_wa;
  logic nh_we, lh_we, nt_we, lt_we, nx_we, nd_we;
  logic [PTR_BITS-1:0] nh_wd, lh_wd, nx_wd;

  logic out_free;
  logic [31:0] in_delay, exp_new, pl_t, newc;
  logic [ID_BITS-1:0] in_id;
  logic pl_near;
  logic [1:0] pl_lvl, mv_lvl;
  logic [LEVEL_BITS-1:0] pl_idx, mv_idx, idx_i;
  logic [PTR_BITS-1:0] pl_head;
  logic [NODE_BITS-1:0] pl_tail;
  logic [NODE_BITS-1:0] ff_idx;
  logic ff_any;
  logic [31:0] id32;

  assign out_free   = !out_v_q || m_axis_tready;
  assign in_delay   = s_axis_tdata[31:0];
  assign in_id      = ID_BITS'(s_axis_tdata[47:32]);
  assign exp_new    = in_delay + tick_q;
  assign newc       = tick_q + 32'd1;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign pl_head    = pl_near_q ? nh_rd_q : lh_rd_q;
  assign pl_tail    = pl_near_q ? nt_rd_q : lt_rd_q;

  // slot choice for a node with expiry pl_t against the current count
  always_comb begin
    pl_t    = (state_q == S_IDLE) ? exp_new : ne_rd_q;
    pl_near = ((pl_t | NEAR_MASK) == (tick_q | NEAR_MASK));
    pl_lvl  = 2'(htw_pkg::LAST_LEVEL);
    for (int i = 2; i >= 0; i--) begin
      if ((pl_t | 32'((64'd1 << (NEAR_BITS + LEVEL_BITS * (i + 1))) - 64'd1)) ==
          (tick_q | 32'((64'd1 << (NEAR_BITS + LEVEL_BITS * (i + 1))) - 64'd1))) begin
        pl_lvl = 2'(i);
      end
    end
    pl_idx = '0;
    for (int i = 0; i < 4; i++) begin
      if (pl_lvl == 2'(i)) begin
        pl_idx = LEVEL_BITS'(pl_t >> (NEAR_BITS + i * LEVEL_BITS));
      end
    end
  end

  // cascade source: lowest non-zero outer index of the new count
  always_comb begin
    mv_lvl = 2'(htw_pkg::LAST_LEVEL);
    mv_idx = '0;
    idx_i  = '0;
    for (int i = 3; i >= 0; i--) begin
      idx_i = LEVEL_BITS'(newc >> (NEAR_BITS + i * LEVEL_BITS));
      if (idx_i != '0) begin
        mv_lvl = 2'(i);
        mv_idx = idx_i;
      end
    end
  end

  always_comb begin
    ff_any = 1'b0;
    ff_idx = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        ff_any = 1'b1;
        ff_idx = NODE_BITS'(i);
      end
    end
  end

  always_comb begin
    nh_ra = tick_q[NEAR_BITS-1:0];
    lh_ra = mv_slot_q;
    nd_ra = cur_q;
    nh_we = 1'b0; nh_wa = tick_q[NEAR_BITS-1:0]; nh_wd = EMPTY;
    lh_we = 1'b0; lh_wa = mv_slot_q;             lh_wd = EMPTY;
    nt_we = 1'b0; lt_we = 1'b0;
    nx_we = 1'b0; nx_wa = cur_q; nx_wd = EMPTY;
    nd_we = 1'b0;
    unique case (state_q)
      S_CLR: begin
        nh_we = 1'b1; nh_wa = clr_q[NEAR_BITS-1:0];
        lh_we = 1'b1; lh_wa = clr_q[LVL_ADDR-1:0];
      end
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == htw_pkg::ACT_ADD &&
            in_delay != '0 && !in_delay[31] && free_any_q) begin
          nd_we = 1'b1;
          nx_we = 1'b1; nx_wa = free_idx_q;
        end
      end
      S_FN_HD: begin
        nh_we = 1'b1;
        nd_ra = nh_rd_q[NODE_BITS-1:0];
      end
      S_FN_EM: nd_ra = nx_q[NODE_BITS-1:0];
      S_MV_HD: begin
        lh_we = 1'b1;
        nd_ra = lh_rd_q[NODE_BITS-1:0];
      end
      S_MV_ND: nx_we = 1'b1;
      S_PL_RD: begin
        nh_ra = pl_nidx_q;
        lh_ra = pl_lidx_q;
      end
      S_PL_WR: begin
        nh_wa = pl_nidx_q; lh_wa = pl_lidx_q;
        nh_wd = {1'b0, cur_q}; lh_wd = {1'b0, cur_q};
        if (pl_head[PTR_BITS-1]) begin
          nh_we = pl_near_q;
          lh_we = !pl_near_q;
        end else begin
          nx_we = 1'b1; nx_wa = pl_tail; nx_wd = {1'b0, cur_q};
        end
        nt_we = pl_near_q;
        lt_we = !pl_near_q;
        nd_ra = nx_q[NODE_BITS-1:0];
      end
      S_FN_RD, S_FN_ND, S_SHIFT, S_MV_RD, S_FLUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nh_we) near_head[nh_wa] <= nh_wd;
    if (nt_we) near_tail[nh_wa] <= cur_q;
    if (lh_we) level_head[lh_wa] <= lh_wd;
    if (lt_we) level_tail[lh_wa] <= cur_q;
    if (nx_we) node_next[nx_wa] <= nx_wd;
    if (nd_we) begin
      node_exp[free_idx_q] <= exp_new;
      node_hdl[free_idx_q] <= in_id;
    end
    nh_rd_q  <= near_head[nh_ra];
    nt_rd_q  <= near_tail[nh_ra];
    lh_rd_q  <= level_head[lh_ra];
    lt_rd_q  <= level_tail[lh_ra];
    nn_rd_q  <= node_next[nd_ra];
    ne_rd_q  <= node_exp[nd_ra];
    nhd_rd_q <= node_hdl[nd_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      tick_q     <= '0;
      phase_q    <= 1'b0;
      from_add_q <= 1'b0;
      cur_q      <= '0;
      nx_q       <= EMPTY;
      hid_q      <= '0;
      pl_near_q  <= 1'b0;
      pl_nidx_q  <= '0;
      pl_lidx_q  <= '0;
      mv_slot_q  <= '0;
      free_q     <= '1;
      free_any_q <= 1'b1;
      free_idx_q <= '0;
      pend_v_q   <= 1'b0;
      pend_id_q  <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_id_q   <= '0;
      out_st_q   <= htw_pkg::ST_EXPIRED;
    end else begin
      free_any_q <= ff_any;
      free_idx_q <= ff_idx;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == htw_pkg::ACT_TICK) begin
              phase_q <= 1'b0;
              state_q <= S_FN_RD;
            end else if (in_delay == '0 || in_delay[31]) begin
              out_v_q <= 1'b1; out_last_q <= 1'b1;
              out_id_q <= htw_pkg::OUT_TDATA_W'(in_id);
              out_st_q <= htw_pkg::ST_FIRED;
            end else if (!free_any_q) begin
              out_v_q <= 1'b1; out_last_q <= 1'b1;
              out_id_q <= htw_pkg::OUT_TDATA_W'(in_id);
              out_st_q <= htw_pkg::ST_REJECTED;
            end else begin
              free_q[free_idx_q] <= 1'b0;
              cur_q      <= free_idx_q;
              from_add_q <= 1'b1;
              pl_near_q  <= pl_near;
              pl_nidx_q  <= pl_t[NEAR_BITS-1:0];
              pl_lidx_q  <= {pl_lvl, pl_idx};
              state_q    <= S_PL_RD;
            end
          end
        end
        S_FN_RD: state_q <= S_FN_HD;
        S_FN_HD: begin
          cur_q <= nh_rd_q[NODE_BITS-1:0];
          if (nh_rd_q[PTR_BITS-1]) state_q <= phase_q ? S_FLUSH : S_SHIFT;
          else state_q <= S_FN_ND;
        end
        S_FN_ND: begin
          nx_q    <= nn_rd_q;
          hid_q   <= nhd_rd_q;
          state_q <= S_FN_EM;
        end
        S_FN_EM: begin
          if (out_free) begin
            if (pend_v_q) begin
              out_v_q <= 1'b1; out_last_q <= 1'b0;
              out_id_q <= id32[15:0];
              out_st_q <= htw_pkg::ST_EXPIRED;
            end
            pend_v_q  <= 1'b1;
            pend_id_q <= hid_q;
            free_q[cur_q] <= 1'b1;
            cur_q <= nx_q[NODE_BITS-1:0];
            if (nx_q[PTR_BITS-1]) state_q <= phase_q ? S_FLUSH : S_SHIFT;
            else state_q <= S_FN_ND;
          end
        end
        S_SHIFT: begin
          tick_q    <= newc;
          mv_slot_q <= {mv_lvl, mv_idx};
          if (newc[NEAR_BITS-1:0] != '0) begin
            phase_q <= 1'b1;
            state_q <= S_FN_RD;
          end else begin
            state_q <= S_MV_RD;
          end
        end
        S_MV_RD: state_q <= S_MV_HD;
        S_MV_HD: begin
          cur_q      <= lh_rd_q[NODE_BITS-1:0];
          from_add_q <= 1'b0;
          if (lh_rd_q[PTR_BITS-1]) begin
            phase_q <= 1'b1;
            state_q <= S_FN_RD;
          end else begin
            state_q <= S_MV_ND;
          end
        end
        S_MV_ND: begin
          nx_q      <= nn_rd_q;
          pl_near_q <= pl_near;
          pl_nidx_q <= pl_t[NEAR_BITS-1:0];
          pl_lidx_q <= {pl_lvl, pl_idx};
          state_q   <= S_PL_RD;
        end
        S_PL_RD: state_q <= S_PL_WR;
        S_PL_WR: begin
          if (from_add_q) begin
            from_add_q <= 1'b0;
            state_q    <= S_IDLE;
          end else if (nx_q[PTR_BITS-1]) begin
            phase_q <= 1'b1;
            state_q <= S_FN_RD;
          end else begin
            cur_q   <= nx_q[NODE_BITS-1:0];
            state_q <= S_MV_ND;
          end
        end
        S_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_v_q <= 1'b1; out_last_q <= 1'b1;
            out_id_q <= id32[15:0];
            out_st_q <= htw_pkg::ST_EXPIRED;
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign id32          = 32'(pend_id_q);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

  a_add_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == htw_pkg::ST_FIRED ||
                       m_axis_tuser == htw_pkg::ST_REJECTED)) |-> m_axis_tlast)
    else $error("add result without last");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_v_q)
    else $error("word taken while a result is held back");

  a_sweep_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (!m_axis_tvalid && !s_axis_tready))
    else $error("traffic during head sweep");

endmodule

// ===== tb/htw_checker.sv =====
// Checker for the hierarchical timing wheel: watches both stream channels, predicts
// the results of each accepted input word and compares them with the output words.
// Depends on htw_pkg.
module htw_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [htw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [htw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic [htw_pkg::STATUS_W-1:0]      m_axis_tuser,
  input  logic                              m_axis_tlast,
  output int                                pending_o,
  output int                                fail_count_o
);

  localparam int unsigned NEAR_BITS  = 8;
  localparam int unsigned LEVEL_BITS = 6;
  localparam int unsigned POOL_SIZE  = 64;
  localparam logic [6:0]  NIL        = 7'h7F;

  typedef struct packed {
    logic [htw_pkg::TID_W-1:0]    id;
    logic [htw_pkg::STATUS_W-1:0] status;
    logic                         last;
  } fire_t;

  logic [31:0]               now_tick;
  logic [6:0]                near_first [256];
  logic [6:0]                near_end   [256];
  logic [6:0]                outer_first[256];
  logic [6:0]                outer_end  [256];
  logic [6:0]                link       [POOL_SIZE];
  logic [31:0]               due        [POOL_SIZE];
  logic [htw_pkg::TID_W-1:0] handle     [POOL_SIZE];
  logic                      idle_node  [POOL_SIZE];

  fire_t due_fires[$];
  int    mismatches;

  assign fail_count_o = mismatches;

  function automatic void link_near(int slot, logic [6:0] n);
    if (near_first[slot] == NIL) near_first[slot] = n;
    else link[near_end[slot]] = n;
    near_end[slot] = n;
    link[n] = NIL;
  endfunction

  function automatic void link_outer(int slot, logic [6:0] n);
    if (outer_first[slot] == NIL) outer_first[slot] = n;
    else link[outer_end[slot]] = n;
    outer_end[slot] = n;
    link[n] = NIL;
  endfunction

  function automatic void file_timer(logic [6:0] n);
    logic [31:0] t;
    logic [31:0] m;
    int          lvl;
    t = due[n];
    if ((t | 32'hFF) == (now_tick | 32'hFF)) begin
      link_near(int'(t[7:0]), n);
      return;
    end
    m = 32'h1 << (NEAR_BITS + LEVEL_BITS);
    lvl = 0;
    while (lvl < 3 && (t | (m - 1)) != (now_tick | (m - 1))) begin
      m = m << LEVEL_BITS;
      lvl++;
    end
    link_outer(lvl * 64 + int'((t >> (NEAR_BITS + lvl * LEVEL_BITS)) & 32'h3F), n);
  endfunction

  function automatic void cascade(int lvl, int idx);
    int         s;
    logic [6:0] cur;
    logic [6:0] nx;
    s = lvl * 64 + idx;
    cur = outer_first[s];
    outer_first[s] = NIL;
    while (cur < POOL_SIZE) begin
      nx = link[cur];
      file_timer(cur);
      cur = nx;
    end
  endfunction

  function automatic void expire_slot(ref fire_t found[$]);
    int         slot;
    logic [6:0] cur;
    slot = int'(now_tick[7:0]);
    cur = near_first[slot];
    near_first[slot] = NIL;
    while (cur < POOL_SIZE) begin
      found.push_back('{handle[cur], htw_pkg::ST_EXPIRED, 1'b0});
      idle_node[cur] = 1'b1;
      cur = link[cur];
    end
  endfunction

  function automatic void advance();
    int idx;
    now_tick++;
    if (now_tick[7:0] != 0) return;
    for (int lvl = 0; lvl < htw_pkg::OUTER_LEVELS; lvl++) begin
      idx = int'((now_tick >> (NEAR_BITS + lvl * LEVEL_BITS)) & 32'h3F);
      if (idx != 0) begin
        cascade(lvl, idx);
        return;
      end
    end
    cascade(htw_pkg::LAST_LEVEL, 0);
  endfunction

  function automatic void predict(logic act, logic [31:0] dly,
                                  logic [htw_pkg::TID_W-1:0] id);
    fire_t found[$];
    int    n;
    if (act == htw_pkg::ACT_ADD) begin
      if (dly == 0 || dly[31]) begin
        due_fires.push_back('{id, htw_pkg::ST_FIRED, 1'b1});
        return;
      end
      n = 0;
      while (n < POOL_SIZE && !idle_node[n]) n++;
      if (n == POOL_SIZE) begin
        due_fires.push_back('{id, htw_pkg::ST_REJECTED, 1'b1});
        return;
      end
      idle_node[n] = 1'b0;
      handle[n] = id;
      due[n] = dly + now_tick;
      file_timer(7'(n));
    end else begin
      expire_slot(found);
      advance();
      expire_slot(found);
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) due_fires.push_back(found[k]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fire_t exp_w;
    if (!rst_ni) begin
      now_tick = '0;
      for (int k = 0; k < 256; k++) begin
        near_first[k] = NIL;
        outer_first[k] = NIL;
      end
      for (int k = 0; k < POOL_SIZE; k++) idle_node[k] = 1'b1;
      due_fires.delete();
      mismatches = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_fires.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: id %h status %0d last %b",
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          exp_w = due_fires.pop_front();
          if (exp_w.id != m_axis_tdata || exp_w.status != m_axis_tuser ||
              exp_w.last != m_axis_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp id %h status %0d last %b, got id %h status %0d last %b",
                       exp_w.id, exp_w.status, exp_w.last,
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32]);
      pending_o = due_fires.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the timing wheel testbench: clock, reset, stimulus and verdict.
// Depends on htw_pkg, hierarchical_timing_wheel_unit and htw_checker.
module testbench;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [htw_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // delay[31:0], timer_id[47:32]
  logic                            s_axis_tuser;   // action
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [htw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // fired_id
  logic [htw_pkg::STATUS_W-1:0]    m_axis_tuser;   // status
  logic                            m_axis_tlast;
  int                              pending;
  int                              fail_count;
  bit                              first_word = 1'b1;

  hierarchical_timing_wheel_unit i_dut (.*);

  htw_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver: per-word stall, with bursts of no stalling
  initial begin
    int stall;
    int served;
    m_axis_tready = 1'b0;
    served = 0;
    @(posedge rst_ni);
    forever begin
      stall = ((served / 40) % 3 == 1) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid) @(negedge clk_i);
      @(posedge clk_i);
      served++;
    end
  end

  task automatic push_word(logic act, logic [31:0] dly, logic [htw_pkg::TID_W-1:0] id,
                           int gap);
    if (gap > 0 && !first_word) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    first_word = 1'b0;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {id, dly};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic random_word(int n);
    int          gap;
    int          r;
    int          add_pct;
    logic [31:0] dly;
    gap = ((n / 50) % 4 == 2) ? 0 : $urandom_range(0, 18);
    add_pct = (n >= 100 && n < 180) ? 90 : 45;
    if ($urandom_range(0, 99) >= add_pct) begin
      push_word(htw_pkg::ACT_TICK, $urandom(), 16'($urandom()), gap);
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 55)      dly = $urandom_range(1, 300);
    else if (r < 70) dly = -$urandom_range(0, 1000);
    else if (r < 80) dly = $urandom_range(300, 3000);
    else             dly = $urandom();
    push_word(htw_pkg::ACT_ADD, dly, 16'($urandom()), gap);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = htw_pkg::ACT_TICK;
    s_axis_tdata  = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_word(htw_pkg::ACT_TICK, 32'h0, 16'h0, 0);
    push_word(htw_pkg::ACT_ADD, 32'h0, 16'h0000, 0);
    push_word(htw_pkg::ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 3);
    push_word(htw_pkg::ACT_ADD, 32'h8000_0000, 16'h1234, 0);
    push_word(htw_pkg::ACT_ADD, 32'h7FFF_FFFF, 16'hFFFF, 1);
    push_word(htw_pkg::ACT_ADD, 32'h1, 16'hA001, 0);
    push_word(htw_pkg::ACT_ADD, 32'h2, 16'hA002, 0);
    push_word(htw_pkg::ACT_ADD, 32'h2, 16'hA003, 2);
    push_word(htw_pkg::ACT_ADD, 32'h100, 16'hB100, 0);
    push_word(htw_pkg::ACT_ADD, 32'h12C, 16'hB12C, 0);
    push_word(htw_pkg::ACT_ADD, 32'h4000, 16'hC000, 0);
    push_word(htw_pkg::ACT_ADD, 32'h0010_0000, 16'hD000, 0);
    push_word(htw_pkg::ACT_ADD, 32'h0400_0000, 16'hE000, 0);
    for (int k = 0; k < 4; k++) push_word(htw_pkg::ACT_TICK, 32'h0, 16'h0, k);

    for (int n = 0; n < 450; n++) begin
      if (n == 220) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
        @(posedge clk_i);
      end
      random_word(n);
    end
    s_axis_tvalid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
